[src/lmc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the local magnitude calculator.
// No dependencies; imported by the top level and by lmc_table.
package lmc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 2'd2;

  localparam logic [30:0] RST_MAX_DIST  = 31'd1310720;  // 20 degrees
  localparam logic [30:0] RST_MAX_DEPTH = 31'd5242880;  // 80 km

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIST  = 2'd1;
  localparam logic [1:0] ST_DEPTH = 2'd2;
  localparam logic [1:0] ST_AMP   = 2'd3;

  localparam logic KIND_LOAD = 1'b0;

  // 111.19492664 km per degree in Q8.24, log10(2) in Q0.32.
  localparam logic [31:0] KM_PER_DEG = 32'd1865541302;
  localparam logic [31:0] LOG10_2    = 32'd1292913986;

  localparam int SQRT_STEPS = 32;
  localparam int LOG_STEPS  = 28;

  typedef struct packed {
    logic [31:0]        limit;
    logic signed [31:0] slope;
    logic signed [31:0] offset;
    logic               nomag;
  } entry_t;

endpackage

[src/lmc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input items and the results.
// Depends on nothing.
interface lmc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  entry_index;
  logic [31:0] entry_range_km;
  logic signed [31:0] entry_slope;
  logic signed [31:0] entry_offset;
  logic        entry_no_magnitude;
  logic [31:0] amplitude;
  logic signed [31:0] epi_deg;
  logic signed [31:0] depth_km;

  modport source (output valid, kind, entry_index, entry_range_km, entry_slope, entry_offset,
                  entry_no_magnitude, amplitude, epi_deg, depth_km, input ready);
  modport sink (input valid, kind, entry_index, entry_range_km, entry_slope, entry_offset,
                entry_no_magnitude, amplitude, epi_deg, depth_km, output ready);
endinterface

interface lmc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] magnitude;

  modport source (output valid, status, magnitude, input ready);
  modport sink (input valid, status, magnitude, output ready);
endinterface

[src/local_magnitude_calculator_top.sv]
`timescale 1ns / 1ps
// Local magnitude calculator: loadable distance table, distance-corrected ML.
// Depends on lmc_pkg, lmc_if, lmc_mul and lmc_table.
//
// Usage: in_ch carries items. kind 0 loads one table entry and returns status 0;
// kind 1 computes a magnitude from amplitude, distance and depth. out_ch returns
// exactly one result per item. cfg_we/cfg_index/cfg_data write the distance and
// depth limits and the number of entries searched; write only while idle.
// A full compute runs a 32-step square root, one table read per entry searched,
// a leading-one shift search over the amplitude and 28 multiply/adjust pairs of
// the log2 squaring loop; the products of that loop and of the distance, log
// and slope steps share one multiplier.
// One item is in work at a time; in_ch.ready is low from the transfer until the
// result is placed in the output register. A result waiting on a stalled
// receiver holds; the next item may be accepted meanwhile, but its result waits.
// Reset restores the default limits and empties the search count; table
// contents are undefined until loaded.
module local_magnitude_calculator_top import lmc_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lmc_in_if.sink                in_ch,
  lmc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_CHECK     = 19'h00002,
    S_EPI_MUL   = 19'h00004,
    S_EPI_RND   = 19'h00008,
    S_E2_MUL    = 19'h00010,
    S_D2_MUL    = 19'h00020,
    S_SUM       = 19'h00040,
    S_SQRT      = 19'h00080,
    S_SCAN      = 19'h00100,
    S_SCAN_END  = 19'h00200,
    S_SELECT    = 19'h00400,
    S_NORM      = 19'h00800,
    S_SQ_MUL    = 19'h01000,
    S_SQ_ADJ    = 19'h02000,
    S_LOG_MUL   = 19'h04000,
    S_LOG_RND   = 19'h08000,
    S_SLOPE_RND = 19'h10000,
    S_SAT       = 19'h20000,
    S_DONE      = 19'h40000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [30:0] max_dist_r, max_depth_r;
  logic [4:0]  entries_r;

  // Captured item
  logic [31:0]        amp_r;
  logic signed [31:0] delta_r, depth_r;

  // Datapath registers
  logic [31:0] epi_r, epi_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] num_r, num_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [CW-1:0] scan_i_r, scan_i_nxt;
  logic        pend_r, pend_nxt;
  logic        found_r, found_nxt;
  entry_t      best_r, best_nxt;
  logic [31:0] y_r, y_nxt;
  logic [4:0]  n_r, n_nxt;
  logic [27:0] frac_r, frac_nxt;
  logic        lneg_r, lneg_nxt;
  logic signed [30:0] log_r, log_nxt;
  logic        sneg_r, sneg_nxt;
  logic signed [50:0] sum_r, sum_nxt;
  logic [1:0]  status_r, status_nxt;
  logic signed [31:0] mag_r, mag_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic signed [31:0] out_mag_r, out_mag_nxt;

  // Shared units
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod_r;
  logic        tbl_we;
  logic [AW-1:0] tbl_waddr;
  entry_t      tbl_wdata, tbl_rdata_r;

  logic        in_xfer;
  logic [CW-1:0] count_w;

  // Combinational helpers
  logic [63:0] epi_rnd;
  logic [32:0] dmag;
  logic [64:0] e_sum;
  logic [63:0] sq_trial;
  logic [32:0] sq_t;
  logic signed [33:0] l2;
  logic [32:0] l2_mag;
  logic [28:0] log_mag;
  logic [32:0] slope_mag;
  logic [47:0] sp_mag;
  logic signed [49:0] sp_s;

  lmc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  lmc_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .raddr   (scan_i_r[AW-1:0]),
    .rdata_r (tbl_rdata_r)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_xfer          = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.magnitude = out_mag_r;

  assign tbl_we    = in_xfer && (in_ch.kind == KIND_LOAD) &&
                     (32'(in_ch.entry_index) < TABLE_DEPTH);
  assign tbl_waddr = AW'(in_ch.entry_index);
  assign tbl_wdata = '{limit: in_ch.entry_range_km, slope: in_ch.entry_slope,
                       offset: in_ch.entry_offset, nomag: in_ch.entry_no_magnitude};

  assign count_w = (32'(entries_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_r);

  assign epi_rnd   = prod_r[63:0] + 64'h0000_0000_0080_0000;
  assign dmag      = depth_r[31] ? (33'd0 - {depth_r[31], depth_r}) : {1'b0, depth_r};
  assign e_sum     = {1'b0, acc_r} + {1'b0, prod_r[63:0]};
  assign sq_trial  = res_r + bit_r;
  assign sq_t      = prod_r[63:31];
  assign l2        = {($signed({1'b0, n_r}) - 6'sd16), 28'd0} + $signed({6'd0, frac_r});
  assign l2_mag    = l2[33] ? 33'(-l2) : 33'(l2);
  assign log_mag   = 29'((prod_r + 65'h8_0000_0000) >> 36);
  assign slope_mag = best_r.slope[31] ? (33'd0 - {best_r.slope[31], best_r.slope})
                                      : {1'b0, best_r.slope};
  assign sp_mag    = 48'((prod_r[63:0] + 64'h8000) >> 16);
  assign sp_s      = sneg_r ? -$signed({2'b00, sp_mag}) : $signed({2'b00, sp_mag});

  always_comb begin
    state_nxt  = state_r;
    epi_nxt    = epi_r;
    acc_nxt    = acc_r;
    num_nxt    = num_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    step_nxt   = step_r;
    scan_i_nxt = scan_i_r;
    pend_nxt   = 1'b0;
    found_nxt  = found_r;
    best_nxt   = best_r;
    y_nxt      = y_r;
    n_nxt      = n_r;
    frac_nxt   = frac_r;
    lneg_nxt   = lneg_r;
    log_nxt    = log_r;
    sneg_nxt   = sneg_r;
    sum_nxt    = sum_r;
    status_nxt = status_r;
    mag_nxt    = mag_r;
    mul_a      = '0;
    mul_b      = '0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_mag_nxt    = out_mag_r;

    // The table read issued last cycle is compared here.
    if (pend_r && (tbl_rdata_r.limit >= res_r[31:0]) &&
        (!found_r || tbl_rdata_r.limit < best_r.limit)) begin
      found_nxt = 1'b1;
      best_nxt  = tbl_rdata_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          status_nxt = ST_OK;
          mag_nxt    = '0;
          state_nxt  = (in_ch.kind == KIND_LOAD) ? S_DONE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (delta_r[31] || (delta_r[30:0] > max_dist_r)) begin
          status_nxt = ST_DIST;
          state_nxt  = S_DONE;
        end else if (!depth_r[31] && (depth_r[30:0] > max_depth_r)) begin
          status_nxt = ST_DEPTH;
          state_nxt  = S_DONE;
        end else if (amp_r == '0) begin
          status_nxt = ST_AMP;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_EPI_MUL;
        end
      end
      S_EPI_MUL: begin
        mul_a     = {2'b00, delta_r[30:0]};
        mul_b     = KM_PER_DEG;
        state_nxt = S_EPI_RND;
      end
      S_EPI_RND: begin
        if (epi_rnd[63:56] != '0) begin
          status_nxt = ST_DIST;
          state_nxt  = S_DONE;
        end else begin
          epi_nxt   = epi_rnd[55:24];
          state_nxt = S_E2_MUL;
        end
      end
      S_E2_MUL: begin
        mul_a     = {1'b0, epi_r};
        mul_b     = epi_r;
        state_nxt = S_D2_MUL;
      end
      S_D2_MUL: begin
        // dmag is at most 2^31, so it fits the 32-bit operand.
        mul_a     = dmag;
        mul_b     = dmag[31:0];
        acc_nxt   = prod_r[63:0];
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (e_sum[64]) begin
          status_nxt = ST_DIST;
          state_nxt  = S_DONE;
        end else begin
          num_nxt   = e_sum[63:0];
          res_nxt   = '0;
          bit_nxt   = 64'h4000_0000_0000_0000;
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (num_r >= sq_trial) begin
          num_nxt = num_r - sq_trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(SQRT_STEPS - 1)) begin
          scan_i_nxt = '0;
          found_nxt  = 1'b0;
          if (count_w == '0) begin
            status_nxt = ST_DIST;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        pend_nxt = 1'b1;
        if (scan_i_r == count_w - CW'(1)) begin
          state_nxt = S_SCAN_END;
        end else begin
          scan_i_nxt = scan_i_r + CW'(1);
        end
      end
      S_SCAN_END: begin
        state_nxt = S_SELECT;
      end
      S_SELECT: begin
        if (!found_r || best_r.nomag) begin
          status_nxt = ST_DIST;
          state_nxt  = S_DONE;
        end else begin
          y_nxt     = amp_r;
          n_nxt     = 5'd31;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (y_r[31]) begin
          step_nxt  = '0;
          frac_nxt  = '0;
          state_nxt = S_SQ_MUL;
        end else begin
          y_nxt = y_r << 1;
          n_nxt = n_r - 5'd1;
        end
      end
      S_SQ_MUL: begin
        mul_a     = {1'b0, y_r};
        mul_b     = y_r;
        state_nxt = S_SQ_ADJ;
      end
      S_SQ_ADJ: begin
        // A square at or above 2 gives a one bit of the log2 fraction.
        if (sq_t[32]) begin
          y_nxt    = sq_t[32:1];
          frac_nxt = {frac_r[26:0], 1'b1};
        end else begin
          y_nxt    = sq_t[31:0];
          frac_nxt = {frac_r[26:0], 1'b0};
        end
        step_nxt  = step_r + 6'd1;
        state_nxt = (step_r == 6'(LOG_STEPS - 1)) ? S_LOG_MUL : S_SQ_MUL;
      end
      S_LOG_MUL: begin
        mul_a     = l2_mag;
        mul_b     = LOG10_2;
        lneg_nxt  = l2[33];
        state_nxt = S_LOG_RND;
      end
      S_LOG_RND: begin
        log_nxt   = lneg_r ? -$signed({2'b00, log_mag}) : $signed({2'b00, log_mag});
        mul_a     = slope_mag;
        mul_b     = res_r[31:0];
        sneg_nxt  = best_r.slope[31];
        state_nxt = S_SLOPE_RND;
      end
      S_SLOPE_RND: begin
        sum_nxt = {{20{log_r[30]}}, log_r} + {sp_s[49], sp_s} +
                  {{19{best_r.offset[31]}}, best_r.offset};
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (sum_r > 51'sd2147483647) begin
          mag_nxt = 32'sh7FFF_FFFF;
        end else if (sum_r < -51'sd2147483648) begin
          mag_nxt = 32'sh8000_0000;
        end else begin
          mag_nxt = sum_r[31:0];
        end
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_mag_nxt    = (status_r == ST_OK) ? mag_r : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      max_dist_r  <= RST_MAX_DIST;
      max_depth_r <= RST_MAX_DEPTH;
      entries_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_DIST:  max_dist_r  <= cfg_data;
          CFG_MAX_DEPTH: max_depth_r <= cfg_data;
          CFG_ENTRIES:   entries_r   <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      amp_r   <= in_ch.amplitude;
      delta_r <= in_ch.epi_deg;
      depth_r <= in_ch.depth_km;
    end
    epi_r        <= epi_nxt;
    acc_r        <= acc_nxt;
    num_r        <= num_nxt;
    res_r        <= res_nxt;
    bit_r        <= bit_nxt;
    step_r       <= step_nxt;
    scan_i_r     <= scan_i_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    y_r          <= y_nxt;
    n_r          <= n_nxt;
    frac_r       <= frac_nxt;
    lneg_r       <= lneg_nxt;
    log_r        <= log_nxt;
    sneg_r       <= sneg_nxt;
    sum_r        <= sum_nxt;
    status_r     <= status_nxt;
    mag_r        <= mag_nxt;
    out_status_r <= out_status_nxt;
    out_mag_r    <= out_mag_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state is not one-hot");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready) else $error("ready high right after an input transfer");

  a_err_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_mag_r == '0)
    else $error("nonzero magnitude with an error status");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> scan_i_r < count_w) else $error("table scan past the count");

endmodule

[src/lmc_mul.sv]
`timescale 1ns / 1ps
// Shared 33 x 32 unsigned multiplier with a registered product.
// Depends on nothing.
module lmc_mul (
  input  logic        clk,
  input  logic [32:0] a,
  input  logic [31:0] b,
  output logic [64:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

[src/lmc_table.sv]
`timescale 1ns / 1ps
// Distance table memory: one write port, one registered read port.
// Depends on lmc_pkg for the entry type.
module lmc_table import lmc_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata_r
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
